// File: rtl/core/sldb_pkg.sv
// ============================================================================
// sldb_pkg
// Shared constants, codes and control structs for the lattice death-birth
// step block.
// ============================================================================
package sldb_pkg;

  // Grid geometry (row and column counts are powers of two)
  localparam int GRID_ROWS  = 64;
  localparam int GRID_COLS  = 64;
  localparam int MAX_KINDS  = 4;
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int COL_W      = $clog2(GRID_COLS);
  localparam int CELL_TOTAL = GRID_ROWS * GRID_COLS;
  localparam int CELL_AW    = $clog2(CELL_TOTAL);
  localparam int CELL_NM1   = CELL_TOTAL - 1;

  // Field widths
  localparam int KIND_W = 3;
  localparam int CNT_W  = 13;
  localparam int Q_W    = 16;
  localparam int WORD_W = 64;
  localparam int CIDX_W = 3;

  // Death test datapath widths
  localparam int PROD_W = Q_W + CNT_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int CMP_W  = ACC_W + 2;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_REPORT = 2'd2,
    REQ_NONE   = 2'd3
  } req_code_t;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_KINDS = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BASE  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_IROW1 = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_IROW2 = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_IROW3 = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_IROW4 = 3'd5;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TARGET,
    S_PICK,
    S_DEATH,
    S_WRITE,
    S_REPORT
  } state_t;

  // Death unit request and response
  typedef struct packed {
    logic              start;
    logic [Q_W-1:0]    draw;
    logic [Q_W-1:0]    base;
    logic [WORD_W-1:0] terms;
    logic [KIND_W-1:0] kinds;
  } dth_req_t;

  typedef struct packed {
    logic done;
    logic dies;
  } dth_res_t;

  // Count bank update
  typedef struct packed {
    logic              en;
    logic [KIND_W-1:0] old_kind;
    logic [KIND_W-1:0] new_kind;
  } cnt_upd_t;

endpackage

// File: rtl/core/sldb_if.sv
// ============================================================================
// sldb_if
// Valid/ready channels: request items in, result items out.
// ============================================================================
interface sldb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  cell_row;
  logic [5:0]  cell_col;
  logic [2:0]  load_value;
  logic [11:0] pick_index;
  logic [15:0] uniform_draw;

  modport source (
    output valid, req_type, cell_row, cell_col, load_value, pick_index, uniform_draw,
    input  ready
  );
  modport sink (
    input  valid, req_type, cell_row, cell_col, load_value, pick_index, uniform_draw,
    output ready
  );
endinterface

interface sldb_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind_tag;
  logic [12:0] result_value;
  logic        last_of_run;

  modport source (
    output valid, kind_tag, result_value, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, kind_tag, result_value, last_of_run,
    output ready
  );
endinterface

// File: rtl/core/sldb_cell_ram.sv
// ============================================================================
// sldb_cell_ram
// Cell store: one write port, one read port, registered read data.
// ============================================================================
module sldb_cell_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [sldb_pkg::CELL_AW-1:0] waddr,
  input  logic [sldb_pkg::KIND_W-1:0]  wdata,
  input  logic [sldb_pkg::CELL_AW-1:0] raddr,
  output logic [sldb_pkg::KIND_W-1:0]  rdata
);
  import sldb_pkg::*;

  logic [KIND_W-1:0] mem [CELL_TOTAL];
  logic [KIND_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sldb_count_bank.sv
// ============================================================================
// sldb_count_bank
// Running count per cell content, updated on every write-back of a cell.
// ============================================================================
module sldb_count_bank (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sldb_pkg::cnt_upd_t          upd,
  input  logic [sldb_pkg::KIND_W-1:0] rd_sel,
  output logic [sldb_pkg::CNT_W-1:0]  rd_data
);
  import sldb_pkg::*;

  logic [CNT_W-1:0] cnt_r   [MAX_KINDS+1];
  logic [CNT_W-1:0] cnt_nxt [MAX_KINDS+1];

  // old content loses one, new content gains one (cancels when equal)
  always_comb begin
    for (int j = 0; j <= MAX_KINDS; j++) begin
      cnt_nxt[j] = cnt_r[j];
      if (upd.en) begin
        if (upd.new_kind == KIND_W'(j)) cnt_nxt[j] = cnt_nxt[j] + CNT_W'(1);
        if (upd.old_kind == KIND_W'(j)) cnt_nxt[j] = cnt_nxt[j] - CNT_W'(1);
      end
    end
  end

  // all cells start empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= MAX_KINDS; j++) begin
        cnt_r[j] <= (j == 0) ? CNT_W'(CELL_TOTAL) : '0;
      end
    end else begin
      for (int j = 0; j <= MAX_KINDS; j++) begin
        cnt_r[j] <= cnt_nxt[j];
      end
    end
  end

  assign rd_data = (rd_sel <= KIND_W'(MAX_KINDS)) ? cnt_r[rd_sel] : '0;

endmodule

// File: rtl/core/sldb_death_unit.sv
// ============================================================================
// sldb_death_unit
// Serial death test: one interaction product per cycle, then one compare.
// ============================================================================
module sldb_death_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sldb_pkg::dth_req_t          req,
  input  logic [sldb_pkg::CNT_W-1:0]  cnt,
  output logic [sldb_pkg::KIND_W-1:0] cnt_sel,
  output sldb_pkg::dth_res_t          res
);
  import sldb_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic                     prod_v_r;
  logic [KIND_W-1:0]        idx_r;
  logic [KIND_W-1:0]        kinds_r;
  logic [WORD_W-1:0]        terms_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [CMP_W-1:0]  lhs_r;

  logic signed [Q_W:0]      diff;
  logic signed [CMP_W-1:0]  lhs_nxt;
  logic signed [CMP_W-1:0]  rhs;
  logic signed [Q_W-1:0]    term;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     more;

  // (draw - base) * (N - 1); both sides of the test divided by 2^14
  assign diff    = $signed({1'b0, req.draw}) - $signed({1'b0, req.base});
  assign lhs_nxt = CMP_W'(diff) * $signed(CMP_W'(CELL_NM1));

  // interaction term of kind idx+1 times its count
  assign term     = $signed(terms_r[{idx_r[1:0], 4'b0000} +: Q_W]);
  assign prod_nxt = term * $signed({1'b0, cnt});
  assign cnt_sel  = idx_r + KIND_W'(1);
  assign more     = (idx_r != kinds_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        prod_v_r <= 1'b0;
      end else if (busy_r) begin
        prod_v_r <= more;
        if (!more && !prod_v_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      idx_r   <= '0;
      kinds_r <= req.kinds;
      terms_r <= req.terms;
      lhs_r   <= lhs_nxt;
      acc_r   <= '0;
    end else if (busy_r) begin
      if (more) begin
        prod_r <= prod_nxt;
        idx_r  <= idx_r + KIND_W'(1);
      end
      if (prod_v_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // interaction sum carries weight 4 against the scaled draw
  assign rhs      = CMP_W'(acc_r) <<< 2;
  assign res.done = done_r;
  assign res.dies = (lhs_r < rhs);

endmodule

// File: rtl/core/stochastic_lattice_death_birth_step.sv
// ============================================================================
// stochastic_lattice_death_birth_step
// Lattice of cells with global death-birth updates, loads and count reports.
// ============================================================================
// Path: a load goes S_TARGET, S_WRITE; an empty-cell update S_TARGET,
//   S_PICK, S_WRITE; an occupied-cell update S_TARGET, S_DEATH (K products
//   through the death unit), S_WRITE; one item is in work at a time.
// Throughput: a report gives K+1 results, one a cycle while the output moves.
// Reset: synchronous; the cell memory is then cleared one cell a cycle, so
//   no item is taken until every cell has been cleared.
module stochastic_lattice_death_birth_step (
  input  logic                             clk,
  input  logic                             rst_n,
  sldb_req_if.sink                         in_req,
  sldb_res_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [sldb_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [sldb_pkg::WORD_W-1:0]      cfg_data
);
  import sldb_pkg::*;

  // configuration
  logic [KIND_W-1:0] kinds_r;
  logic [WORD_W-1:0] base_r;
  logic [WORD_W-1:0] irow_r [MAX_KINDS];
  logic [KIND_W-1:0] act_kinds;

  // control
  state_t             state_r, state_nxt;
  logic [CELL_AW-1:0] clr_addr_r;
  logic               in_acc;
  logic               out_free;

  // item registers
  logic [CELL_AW-1:0] tgt_addr_r;
  logic [CELL_AW-1:0] pick_addr_r;
  logic [Q_W-1:0]     draw_r;
  logic               is_load_r;
  logic [KIND_W-1:0]  old_r;
  logic [KIND_W-1:0]  new_r;
  logic [KIND_W-1:0]  rep_idx_r;
  logic [KIND_W-1:0]  load_kind;
  logic [CELL_AW-1:0] in_addr;

  // output register
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_tag_r;
  logic [CNT_W-1:0]   out_val_r;
  logic               out_last_r;
  logic               out_load;
  logic [KIND_W-1:0]  out_tag_nxt;
  logic [CNT_W-1:0]   out_val_nxt;
  logic               out_last_nxt;

  // memory, counts, death unit
  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [KIND_W-1:0]  ram_wdata;
  logic [CELL_AW-1:0] ram_raddr;
  logic [KIND_W-1:0]  ram_rdata;
  cnt_upd_t           cnt_upd;
  logic [KIND_W-1:0]  cnt_rd_sel;
  logic [CNT_W-1:0]   cnt_rd;
  logic [KIND_W-1:0]  dth_sel;
  dth_req_t           dth_req;
  dth_res_t           dth_res;
  logic [1:0]         slot;

  // K clamped to 1..MAX_KINDS
  always_comb begin
    if (kinds_r == '0) begin
      act_kinds = KIND_W'(1);
    end else if (kinds_r > KIND_W'(MAX_KINDS)) begin
      act_kinds = KIND_W'(MAX_KINDS);
    end else begin
      act_kinds = kinds_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kinds_r <= KIND_W'(3);
      base_r  <= '0;
      for (int j = 0; j < MAX_KINDS; j++) irow_r[j] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KINDS: kinds_r   <= cfg_data[KIND_W-1:0];
        CFG_BASE:  base_r    <= cfg_data;
        CFG_IROW1: irow_r[0] <= cfg_data;
        CFG_IROW2: irow_r[1] <= cfg_data;
        CFG_IROW3: irow_r[2] <= cfg_data;
        CFG_IROW4: irow_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // flat cell address, column major
  assign in_addr   = {in_req.cell_col[COL_W-1:0], in_req.cell_row[ROW_W-1:0]};
  assign load_kind = (in_req.load_value <= act_kinds) ? in_req.load_value : '0;
  assign in_acc    = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_res.ready;
  assign slot      = ram_rdata[1:0] - 2'd1;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + CELL_AW'(1);
    end
  end

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    in_req.ready  = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = tgt_addr_r;
    ram_wdata     = new_r;
    ram_raddr     = in_addr;
    cnt_upd       = '0;
    cnt_rd_sel    = dth_sel;
    out_load      = 1'b0;
    out_tag_nxt   = new_r;
    out_val_nxt   = CNT_W'(new_r);
    out_last_nxt  = 1'b1;
    dth_req.start = 1'b0;
    dth_req.draw  = draw_r;
    dth_req.base  = base_r[{slot, 4'b0000} +: Q_W];
    dth_req.terms = irow_r[slot];
    dth_req.kinds = act_kinds;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == CELL_AW'(CELL_NM1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        // ready is high throughout, so valid alone marks the item
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          case (in_req.req_type)
            REQ_LOAD, REQ_UPDATE: state_nxt = S_TARGET;
            REQ_REPORT:           state_nxt = S_REPORT;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_TARGET: begin
        // target cell content is on the read port now
        if (is_load_r) begin
          state_nxt = S_WRITE;
        end else if (ram_rdata != '0) begin
          dth_req.start = 1'b1;
          state_nxt     = S_DEATH;
        end else begin
          ram_raddr = pick_addr_r;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        state_nxt = S_WRITE;
      end
      S_DEATH: begin
        if (dth_res.done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          ram_we           = 1'b1;
          cnt_upd.en       = 1'b1;
          cnt_upd.old_kind = old_r;
          cnt_upd.new_kind = new_r;
          out_load         = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_REPORT: begin
        cnt_rd_sel   = rep_idx_r;
        out_tag_nxt  = rep_idx_r;
        out_val_nxt  = cnt_rd;
        out_last_nxt = (rep_idx_r == act_kinds);
        if (out_free) begin
          out_load = 1'b1;
          if (rep_idx_r == act_kinds) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // item registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_addr_r  <= in_addr;
      pick_addr_r <= in_req.pick_index[CELL_AW-1:0];
      draw_r      <= in_req.uniform_draw;
      is_load_r   <= (in_req.req_type == REQ_LOAD);
      new_r       <= load_kind;
      rep_idx_r   <= '0;
    end
    case (state_r)
      S_TARGET: old_r <= ram_rdata;
      S_PICK:   new_r <= ram_rdata;
      S_DEATH:  if (dth_res.done) new_r <= dth_res.dies ? '0 : old_r;
      S_REPORT: if (out_free) rep_idx_r <= rep_idx_r + KIND_W'(1);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tag_r  <= out_tag_nxt;
      out_val_r  <= out_val_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.kind_tag     = out_tag_r;
  assign out_res.result_value = out_val_r;
  assign out_res.last_of_run  = out_last_r;

  // submodules
  sldb_cell_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sldb_count_bank u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (cnt_upd),
    .rd_sel  (cnt_rd_sel),
    .rd_data (cnt_rd)
  );

  sldb_death_unit u_dth (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dth_req),
    .cnt     (cnt_rd),
    .cnt_sel (dth_sel),
    .res     (dth_res)
  );

`ifndef SYNTH
  // death unit only answers while the controller waits for it
  a_dth_done: assert property (@(posedge clk) disable iff (!rst_n)
    dth_res.done |-> (state_r == S_DEATH))
    else $error("death unit done outside death state");

  // memory is written only by the clearing pass or the write-back
  a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_WRITE))
    else $error("cell memory written outside clear or write-back");

  // clearing pass covers every cell before items are taken
  a_clr_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && state_nxt == S_IDLE) |-> (clr_addr_r == CELL_AW'(CELL_NM1)))
    else $error("clearing pass ended early");

  // a write-back always leaves a final result in the output register
  a_wb_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && out_free) |=> (out_valid_r && out_last_r))
    else $error("write-back without final result");
`endif

endmodule

// File: dv/stochastic_lattice_death_birth_step_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// stochastic_lattice_death_birth_step_tb
// Self-checking bench for the lattice death-birth block. A scoreboard keeps
// its own copy of the grid, the per-kind counts and the registers, predicts
// the result items of every accepted request, and compares them in order
// with what leaves the block. Directed corner cases come first, then random
// traffic concentrated on a small patch of the grid, across several register
// settings, with random gaps on both channels and one long output hold-off.
// ============================================================================
module stochastic_lattice_death_birth_step_tb;
  import sldb_pkg::*;

  localparam int STALL_LIMIT = 12000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 16;

  typedef struct packed {
    req_code_t   req_type;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [2:0]  load_value;
    logic [11:0] pick_index;
    logic [15:0] uniform_draw;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  kind_tag;
    logic [12:0] result_value;
    logic        last_of_run;
  } result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: grid mirror, count mirror, registers and pending results
  // --------------------------------------------------------------------------
  class lattice_scoreboard;
    logic [2:0]  cells [CELL_TOTAL];
    int          counts [MAX_KINDS+1];
    logic [2:0]  kinds_reg;
    logic [63:0] base_word;
    logic [63:0] irow [4];
    result_t     due_results [$];
    int          errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (counts[i]) counts[i] = 0;
      counts[0] = CELL_TOTAL;
      kinds_reg = 3'd3;
      base_word = '0;
      foreach (irow[i]) irow[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_KINDS: kinds_reg = data[2:0];
        CFG_BASE:  base_word = data;
        CFG_IROW1: irow[0] = data;
        CFG_IROW2: irow[1] = data;
        CFG_IROW3: irow[2] = data;
        CFG_IROW4: irow[3] = data;
        default: ;
      endcase
    endfunction

    // zero acts as one kind, anything above the maximum as the maximum
    function int unsigned active_kinds();
      if (kinds_reg < 1) return 1;
      if (kinds_reg > MAX_KINDS) return MAX_KINDS;
      return kinds_reg;
    endfunction

    function void store_cell(int unsigned idx, int unsigned v);
      counts[cells[idx]]--;
      cells[idx] = 3'(v);
      counts[v]++;
    endfunction

    function void queue_result(int unsigned tag, int unsigned val, bit last);
      result_t r;
      r.kind_tag     = 3'(tag);
      r.result_value = 13'(val);
      r.last_of_run  = last;
      due_results.push_back(r);
    endfunction

    // work out the results of one accepted request and apply it to the mirror
    function void note_request(req_item_t it);
      int unsigned k, idx, pick, s, v;
      longint      base, acc, term, lhs, rhs;
      logic [15:0] raw;
      k    = active_kinds();
      idx  = (it.cell_col % GRID_COLS) * GRID_ROWS + (it.cell_row % GRID_ROWS);
      pick = it.pick_index % CELL_TOTAL;
      case (it.req_type)
        REQ_LOAD: begin
          v = (it.load_value <= k) ? it.load_value : 0;
          store_cell(idx, v);
          queue_result(v, v, 1'b1);
        end
        REQ_UPDATE: begin
          s = cells[idx];
          if (s != 0) begin
            // death test at scale 2^30; counts include the target itself
            base = base_word[16*(s-1) +: 16];
            acc  = 0;
            for (int i = 1; i <= k; i++) begin
              raw  = irow[s-1][16*(i-1) +: 16];
              term = $signed(raw);
              acc += term * longint'(counts[i]);
            end
            lhs = longint'(it.uniform_draw) * CELL_NM1 * 16384;
            rhs = base * CELL_NM1 * 16384 + acc * 65536;
            v   = (lhs < rhs) ? 0 : s;
          end else begin
            v = cells[pick];
          end
          store_cell(idx, v);
          queue_result(v, v, 1'b1);
        end
        REQ_REPORT: begin
          for (int i = 0; i <= k; i++) queue_result(i, counts[i], i == k);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] tag, logic [12:0] val, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing pending: tag %0d value %0d last %0b",
                 $time, tag, val, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (tag !== want.kind_tag) begin
        $display("%0t: kind_tag expected %0d actual %0d", $time, want.kind_tag, tag);
        errors++;
      end
      if (val !== want.result_value) begin
        $display("%0t: result_value expected %0d actual %0d",
                 $time, want.result_value, val);
        errors++;
      end
      if (last !== want.last_of_run) begin
        $display("%0t: last_of_run expected %0b actual %0b",
                 $time, want.last_of_run, last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels and the block
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  sldb_req_if req_ch ();
  sldb_res_if res_ch ();

  lattice_scoreboard sb;

  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_off_req = 1'b0;

  stochastic_lattice_death_birth_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic req_item_t item_of(req_code_t rq, int row, int col, int lv,
                                        int pick, int draw);
    req_item_t it;
    it.req_type     = rq;
    it.cell_row     = 6'(row);
    it.cell_col     = 6'(col);
    it.load_value   = 3'(lv);
    it.pick_index   = 12'(pick);
    it.uniform_draw = 16'(draw);
    return it;
  endfunction

  // mostly well-formed traffic on an 8x8 patch so that births copy live cells
  function automatic req_item_t random_item();
    req_item_t it;
    int        roll;
    it = item_of(req_code_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      it.req_type = REQ_LOAD;
      it.cell_row = 6'($urandom_range(0, 7));
      it.cell_col = 6'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0) it.load_value = 3'($urandom_range(1, MAX_KINDS));
    end else if (roll < 80) begin
      it.req_type = REQ_UPDATE;
      it.cell_row = 6'($urandom_range(0, 7));
      it.cell_col = 6'($urandom_range(0, 7));
      if ($urandom_range(0, 4) != 0)
        it.pick_index = 12'($urandom_range(0, 7) * GRID_ROWS + $urandom_range(0, 7));
    end else if (roll < 88) begin
      it.req_type = REQ_REPORT;
    end else if (roll < 92) begin
      it.req_type = REQ_NONE;
    end
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(req_item_t it);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= it.req_type;
    req_ch.cell_row     <= it.cell_row;
    req_ch.cell_col     <= it.cell_col;
    req_ch.load_value   <= it.load_value;
    req_ch.pick_index   <= it.pick_index;
    req_ch.uniform_draw <= it.uniform_draw;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic random_burst(int n);
    repeat (n) send_item(random_item());
  endtask

  // stop offering, wait for every pending result, then let the block settle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(logic [63:0] kinds, logic [63:0] base, logic [63:0] r1,
                           logic [63:0] r2, logic [63:0] r3, logic [63:0] r4);
    drain();
    write_reg(CFG_KINDS, kinds);
    write_reg(CFG_BASE, base);
    write_reg(CFG_IROW1, r1);
    write_reg(CFG_IROW2, r2);
    write_reg(CFG_IROW3, r3);
    write_reg(CFG_IROW4, r4);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pack4(logic [15:0] a, logic [15:0] b,
                                        logic [15:0] c, logic [15:0] d);
    return {d, c, b, a};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_LOAD;
    req_ch.cell_row     = '0;
    req_ch.cell_col     = '0;
    req_ch.load_value   = '0;
    req_ch.pick_index   = '0;
    req_ch.uniform_draw = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // three kinds, mixed base probabilities, random interactions
    configure({61'(rand64()), 3'd3}, pack4(16'h8000, 16'h2000, 16'hF000, 16'h0400),
              rand64(), rand64(), rand64(), rand64());

    // directed: empty grid, corner loads, load values past K, death extremes
    send_item(item_of(REQ_REPORT, 0, 0, 0, 0, 0));
    send_item(item_of(REQ_LOAD, 0, 0, 1, 4095, 65535));
    send_item(item_of(REQ_LOAD, 63, 63, 2, 0, 0));
    send_item(item_of(REQ_LOAD, 0, 63, 3, 0, 0));
    send_item(item_of(REQ_LOAD, 63, 0, 4, 0, 0));
    send_item(item_of(REQ_LOAD, 5, 5, 7, 0, 0));
    send_item(item_of(REQ_LOAD, 1, 0, 0, 0, 0));
    send_item(item_of(REQ_UPDATE, 0, 0, 0, 0, 0));
    send_item(item_of(REQ_LOAD, 0, 0, 1, 0, 0));
    send_item(item_of(REQ_UPDATE, 0, 0, 0, 0, 65535));
    send_item(item_of(REQ_UPDATE, 2, 0, 0, 4095, 0));
    send_item(item_of(REQ_UPDATE, 3, 0, 0, 0, 0));
    send_item(item_of(REQ_UPDATE, 63, 63, 7, 4095, 65535));
    send_item(item_of(REQ_NONE, 63, 63, 7, 4095, 65535));
    send_item(item_of(REQ_REPORT, 63, 63, 7, 4095, 65535));
    random_burst(70);

    // all four kinds, no base death, strongest positive interactions;
    // the result side holds off for a long stretch here
    configure({61'(rand64()), 3'd7}, 64'd0, {4{16'h7FFF}}, {4{16'h7FFF}},
              {4{16'h7FFF}}, {4{16'h7FFF}});
    hold_off_req = 1'b1;
    random_burst(85);

    // one kind only, so loaded kinds 2..4 lie above K; full base death,
    // most negative interactions
    configure({61'(rand64()), 3'd0}, {4{16'hFFFF}}, {4{16'h8000}}, {4{16'h8000}},
              {4{16'h8000}}, {4{16'h8000}});
    send_item(item_of(REQ_UPDATE, 63, 63, 0, 0, 0));
    send_item(item_of(REQ_REPORT, 0, 0, 0, 0, 0));
    random_burst(85);

    // two kinds, random terms, back-to-back traffic on both sides
    configure({61'(rand64()), 3'd2}, rand64(), rand64(), rand64(), rand64(), rand64());
    send_idle = 1'b0;
    recv_idle = 1'b0;
    random_burst(85);

    // four kinds, random terms, gaps again
    configure({61'(rand64()), 3'd4}, rand64(), rand64(), rand64(), rand64(), rand64());
    send_idle = 1'b1;
    recv_idle = 1'b1;
    random_burst(85);

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random ready gaps, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 4) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      sb.check_result(res_ch.kind_tag, res_ch.result_value, res_ch.last_of_run);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any item moving on either channel
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: stochastic_lattice_death_birth_step.f
rtl/core/sldb_pkg.sv
rtl/core/sldb_if.sv
rtl/core/sldb_cell_ram.sv
rtl/core/sldb_count_bank.sv
rtl/core/sldb_death_unit.sv
rtl/core/stochastic_lattice_death_birth_step.sv
dv/stochastic_lattice_death_birth_step_tb.sv
